[sv/rcba_pkg.sv]
// Package: sizes, codes and control types shared by the block allocator modules.
package rcba_pkg;

  localparam int NUM_BLOCKS = 64;
  localparam int COUNT_BITS = 16;

  localparam int CMD_W    = 2;
  localparam int ID_W     = 7;
  localparam int STATUS_W = 3;
  localparam int CAP_W    = 7;

  localparam int BLK_IDX_W  = $clog2(NUM_BLOCKS);
  localparam int LIVE_CNT_W = $clog2(NUM_BLOCKS + 1);

  localparam int GRP_SIZE  = 8;
  localparam int GRP_POS_W = $clog2(GRP_SIZE);
  localparam int NUM_GRPS  = (NUM_BLOCKS + GRP_SIZE - 1) / GRP_SIZE;
  localparam int GRP_IDX_W = (NUM_GRPS > 1) ? $clog2(NUM_GRPS) : 1;
  localparam int PAD_BLKS  = NUM_GRPS * GRP_SIZE;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  localparam int OUT_GRANT_LSB  = 0;
  localparam int OUT_STATUS_LSB = ID_W;
  localparam int OUT_LIVE_LSB   = ID_W + STATUS_W;
  localparam int OUT_USED_W     = 2 * ID_W + STATUS_W;

  localparam logic [CAP_W-1:0]      CAP_RESET = 7'd64;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_ADD_REF = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_NO_FREE      = 3'd1,
    ST_ID_IGNORED   = 3'd2,
    ST_SATURATED    = 3'd3,
    ST_FREE_RELEASE = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } dp_cmd_t;

endpackage

[sv/rcba_ctrl.sv]
// Controller: transaction sequencing and output valid for the block allocator.
module rcba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output rcba_pkg::dp_cmd_t dp_cmd
);
  import rcba_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready      = 1'b0;
    dp_cmd.capture = 1'b0;
    dp_cmd.commit  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready      = 1'b1;
        dp_cmd.capture = in_tvalid;
      end
      S_EXEC: begin
        dp_cmd.commit = slot_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (dp_cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

[sv/rcba_datapath.sv]
// Datapath: count memory, live bitmap, free-block search and result register.
module rcba_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rcba_pkg::dp_cmd_t                   dp_cmd,
  input  logic [rcba_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                cfg_wr_en,
  input  logic [rcba_pkg::CAP_W-1:0]          cfg_wr_data,
  output logic [rcba_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import rcba_pkg::*;

  logic [COUNT_BITS-1:0] cnt_mem [NUM_BLOCKS];
  logic [COUNT_BITS-1:0] rd_data_r;

  logic [NUM_BLOCKS-1:0] live_r;
  logic [LIVE_CNT_W-1:0] live_count_r, live_count_nxt;
  logic [CAP_W-1:0]      cap_r;

  cmd_t                  cmd_r;
  logic [ID_W-1:0]       id_r;
  logic [BLK_IDX_W-1:0]  idx_r;

  cmd_t                  in_cmd;
  logic [ID_W-1:0]       in_id;
  logic [BLK_IDX_W-1:0]  in_idx;

  logic [CAP_W-1:0]      usable;
  logic [PAD_BLKS-1:0]   live_pad;
  logic [PAD_BLKS-1:0]   free_v;
  logic [NUM_GRPS-1:0]   grp_found, grp_found_r;
  logic [GRP_POS_W-1:0]  grp_pos   [NUM_GRPS];
  logic [GRP_POS_W-1:0]  grp_pos_r [NUM_GRPS];

  logic                  alloc_found;
  logic [GRP_IDX_W-1:0]  alloc_grp;
  logic [BLK_IDX_W-1:0]  alloc_idx;
  logic                  cur_live;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic                  id_bad;

  logic [ID_W-1:0]       granted;
  status_t               status;
  logic                  we;
  logic [BLK_IDX_W-1:0]  wr_idx;
  logic [COUNT_BITS-1:0] wr_data;
  logic                  live_set, live_clr;

  logic [ID_W-1:0]       out_granted_r;
  status_t               out_status_r;
  logic [ID_W-1:0]       out_live_r;

  assign in_cmd = cmd_t'(in_tdata[CMD_W-1:0]);
  assign in_id  = in_tdata[CMD_W +: ID_W];
  assign in_idx = BLK_IDX_W'(in_id - ID_W'(1));

  // free-block search, first level: lowest free slot per group
  assign usable   = (int'(cap_r) > NUM_BLOCKS) ? CAP_W'(NUM_BLOCKS) : cap_r;
  assign live_pad = PAD_BLKS'(live_r);

  always_comb begin
    for (int i = 0; i < PAD_BLKS; i++) begin
      free_v[i] = !live_pad[i] && (i < int'(usable));
    end
    for (int g = 0; g < NUM_GRPS; g++) begin
      grp_found[g] = |free_v[g*GRP_SIZE +: GRP_SIZE];
      grp_pos[g]   = '0;
      for (int p = GRP_SIZE - 1; p >= 0; p--) begin
        if (free_v[g*GRP_SIZE + p]) grp_pos[g] = GRP_POS_W'(p);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      cmd_r       <= in_cmd;
      id_r        <= in_id;
      idx_r       <= in_idx;
      rd_data_r   <= cnt_mem[in_idx];
      grp_found_r <= grp_found;
      grp_pos_r   <= grp_pos;
    end
  end

  // second level: lowest group holding a free slot
  always_comb begin
    alloc_found = |grp_found_r;
    alloc_grp   = '0;
    for (int g = NUM_GRPS - 1; g >= 0; g--) begin
      if (grp_found_r[g]) alloc_grp = GRP_IDX_W'(g);
    end
    alloc_idx = BLK_IDX_W'({alloc_grp, grp_pos_r[alloc_grp]});
  end

  assign cur_live = live_r[idx_r];
  assign cur_cnt  = cur_live ? rd_data_r : '0;
  assign id_bad   = (id_r == '0) || (int'(id_r) > NUM_BLOCKS);

  always_comb begin
    granted  = '0;
    status   = ST_OK;
    we       = 1'b0;
    wr_idx   = idx_r;
    wr_data  = '0;
    live_set = 1'b0;
    live_clr = 1'b0;
    unique case (cmd_r)
      CMD_ALLOC: begin
        if (alloc_found) begin
          we       = 1'b1;
          wr_idx   = alloc_idx;
          wr_data  = COUNT_BITS'(1);
          live_set = 1'b1;
          granted  = ID_W'(alloc_idx) + ID_W'(1);
        end else begin
          status = ST_NO_FREE;
        end
      end
      CMD_ADD_REF: begin
        if (id_bad) begin
          status = ST_ID_IGNORED;
        end else if (cur_cnt == COUNT_MAX) begin
          status = ST_SATURATED;
        end else begin
          we       = 1'b1;
          wr_data  = cur_cnt + COUNT_BITS'(1);
          live_set = !cur_live;
        end
      end
      CMD_RELEASE: begin
        if (id_bad) begin
          status = ST_ID_IGNORED;
        end else if (!cur_live) begin
          status = ST_FREE_RELEASE;
        end else begin
          we       = 1'b1;
          wr_data  = cur_cnt - COUNT_BITS'(1);
          live_clr = (cur_cnt == COUNT_BITS'(1));
        end
      end
      CMD_NOP: ;
      default: ;
    endcase
  end

  always_comb begin
    live_count_nxt = live_count_r;
    if (live_set) live_count_nxt = live_count_r + LIVE_CNT_W'(1);
    else if (live_clr) live_count_nxt = live_count_r - LIVE_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.commit && we) cnt_mem[wr_idx] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.commit) begin
      out_granted_r <= granted;
      out_status_r  <= status;
      out_live_r    <= ID_W'(live_count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r       <= '0;
      live_count_r <= '0;
      cap_r        <= CAP_RESET;
    end else begin
      if (cfg_wr_en) cap_r <= cfg_wr_data;
      if (dp_cmd.commit) begin
        live_count_r <= live_count_nxt;
        if (live_set) live_r[wr_idx] <= 1'b1;
        else if (live_clr) live_r[wr_idx] <= 1'b0;
      end
    end
  end

  assign out_tdata = {{(OUT_TDATA_W - OUT_USED_W){1'b0}},
                      out_live_r, out_status_r, out_granted_r};

endmodule

[sv/refcount_block_allocator.sv]
// Top level: reference-counted pool block allocator.
// Usage:
//   Input stream (in_*) carries one command per transaction: allocate,
//   add reference, release reference or no-op, with a 1-based block id.
//   Output stream (out_*) returns exactly one result per command: granted
//   id, status code and the number of live blocks after the command.
//   cfg_wr_en/cfg_wr_data set the allocation capacity; write only while idle.
// Timing:
//   A command is handled in a capture step, which reads the block counter
//   from memory and runs the per-group free search, then an execute step,
//   which finishes the search, updates the counter and loads the result
//   register and out_tvalid, waiting while an earlier result is untaken.
//   The next command is accepted in the cycle after the result is loaded.
// Reset:
//   Synchronous active-low rst_n frees every block, clears the live count
//   and sets capacity to 64. No clearing pass is needed.
// Backpressure:
//   A result waits in the output register while out_tready is low; one more
//   command is accepted and held until that result is taken.
module refcount_block_allocator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [1:0] command, [8:2] block_ref
  input  logic [rcba_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [6:0] granted_id, [9:7] status, [16:10] live_blocks
  output logic [rcba_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_wr_en,
  input  logic [rcba_pkg::CAP_W-1:0]          cfg_wr_data
);
  import rcba_pkg::*;

  dp_cmd_t dp_cmd;

  rcba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .dp_cmd     (dp_cmd)
  );

  rcba_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .dp_cmd      (dp_cmd),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tdata   (out_tdata)
  );

  logic [ID_W-1:0]     chk_granted;
  logic [STATUS_W-1:0] chk_status;
  logic [ID_W-1:0]     chk_live;

  assign chk_granted = out_tdata[OUT_GRANT_LSB +: ID_W];
  assign chk_status  = out_tdata[OUT_STATUS_LSB +: STATUS_W];
  assign chk_live    = out_tdata[OUT_LIVE_LSB +: ID_W];

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second command accepted while one is in flight");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> ##1 out_tvalid)
    else $error("no result two cycles after command acceptance");

  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (chk_granted != '0) |-> chk_status == ST_OK)
    else $error("block granted with non-ok status");

  a_live_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> int'(chk_live) <= NUM_BLOCKS && int'(chk_granted) <= NUM_BLOCKS)
    else $error("live count or granted id out of range");

endmodule

[tb/tb.sv]
// Self-checking testbench for the reference-counted block allocator.
`timescale 1ns / 100ps

module tb;
  import rcba_pkg::*;

  localparam int LIMIT      = 2_000_000;
  localparam int RAND_ITEMS = 135;
  localparam int HOLD_OFF   = 300;

  typedef struct packed {
    logic [ID_W-1:0] granted;
    status_t         status;
    logic [ID_W-1:0] live;
  } alloc_rslt_t;

  typedef struct packed {
    logic            is_cfg;
    cmd_t            cmd;
    logic [ID_W-1:0] arg;
    logic            typed;
    alloc_rslt_t     res;
  } dir_row_t;

  localparam alloc_rslt_t NO_RES = '{7'd0, ST_OK, 7'd0};

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]       cfg_wr_data = '0;

  // pool model state
  logic [COUNT_BITS-1:0] blk_cnt [NUM_BLOCKS];
  int                    live_q = 0;
  logic [CAP_W-1:0]      cap_q = CAP_RESET;

  alloc_rslt_t owed_results[$];
  int          bad_results = 0;
  int          send_idle = 21;
  int          recv_idle = 79;
  int          stall_left = 0;
  int unsigned cycle_cnt = 0;

  // directed commands; rows with typed = 0 take the model's answer
  dir_row_t dir_tbl [0:24] = '{
    '{1'b0, CMD_ALLOC,   7'd0,   1'b1, '{7'd1, ST_OK, 7'd1}},
    '{1'b0, CMD_ALLOC,   7'd127, 1'b1, '{7'd2, ST_OK, 7'd2}},
    '{1'b0, CMD_ADD_REF, 7'd0,   1'b1, '{7'd0, ST_ID_IGNORED, 7'd2}},
    '{1'b0, CMD_RELEASE, 7'd0,   1'b1, '{7'd0, ST_ID_IGNORED, 7'd2}},
    '{1'b0, CMD_ADD_REF, 7'd127, 1'b1, '{7'd0, ST_ID_IGNORED, 7'd2}},
    '{1'b0, CMD_RELEASE, 7'd65,  1'b1, '{7'd0, ST_ID_IGNORED, 7'd2}},
    '{1'b0, CMD_RELEASE, 7'd64,  1'b1, '{7'd0, ST_FREE_RELEASE, 7'd2}},
    '{1'b0, CMD_ADD_REF, 7'd64,  1'b1, '{7'd0, ST_OK, 7'd3}},
    '{1'b0, CMD_NOP,     7'd85,  1'b1, '{7'd0, ST_OK, 7'd3}},
    '{1'b0, CMD_ADD_REF, 7'd1,   1'b0, NO_RES},
    '{1'b0, CMD_RELEASE, 7'd1,   1'b0, NO_RES},
    '{1'b0, CMD_RELEASE, 7'd1,   1'b0, NO_RES},
    '{1'b0, CMD_RELEASE, 7'd1,   1'b1, '{7'd0, ST_FREE_RELEASE, 7'd2}},
    '{1'b1, CMD_NOP,     7'd0,   1'b0, NO_RES},
    '{1'b0, CMD_ALLOC,   7'd42,  1'b1, '{7'd0, ST_NO_FREE, 7'd2}},
    '{1'b1, CMD_NOP,     7'd1,   1'b0, NO_RES},
    '{1'b0, CMD_ALLOC,   7'd0,   1'b0, NO_RES},
    '{1'b0, CMD_ALLOC,   7'd0,   1'b1, '{7'd0, ST_NO_FREE, 7'd3}},
    '{1'b0, CMD_ADD_REF, 7'd5,   1'b0, NO_RES},
    '{1'b0, CMD_RELEASE, 7'd5,   1'b0, NO_RES},
    '{1'b1, CMD_NOP,     7'd127, 1'b0, NO_RES},
    '{1'b0, CMD_ALLOC,   7'd0,   1'b0, NO_RES},
    '{1'b0, CMD_RELEASE, 7'd2,   1'b0, NO_RES},
    '{1'b0, CMD_RELEASE, 7'd64,  1'b0, NO_RES},
    '{1'b1, CMD_NOP,     7'd64,  1'b0, NO_RES}
  };

  refcount_block_allocator DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic alloc_rslt_t pool_step(input cmd_t c, input logic [ID_W-1:0] id);
    alloc_rslt_t r;
    int lim;
    int k;
    r = NO_RES;
    lim = (cap_q > NUM_BLOCKS) ? NUM_BLOCKS : int'(cap_q);
    k = int'(id) - 1;
    case (c)
      CMD_ALLOC: begin
        r.status = ST_NO_FREE;
        for (int i = 0; i < lim; i++) begin
          if (r.status == ST_NO_FREE && blk_cnt[i] == '0) begin
            blk_cnt[i] = COUNT_BITS'(1);
            live_q++;
            r.granted = ID_W'(i + 1);
            r.status = ST_OK;
          end
        end
      end
      CMD_ADD_REF, CMD_RELEASE: begin
        if (id == 0 || id > NUM_BLOCKS) begin
          r.status = ST_ID_IGNORED;
        end else if (c == CMD_ADD_REF) begin
          if (blk_cnt[k] == COUNT_MAX) begin
            r.status = ST_SATURATED;
          end else begin
            if (blk_cnt[k] == '0) live_q++;
            blk_cnt[k] = blk_cnt[k] + 1'b1;
          end
        end else if (blk_cnt[k] == '0) begin
          r.status = ST_FREE_RELEASE;
        end else begin
          if (blk_cnt[k] == 1) live_q--;
          blk_cnt[k] = blk_cnt[k] - 1'b1;
        end
      end
      default: ;
    endcase
    r.live = live_q[ID_W-1:0];
    return r;
  endfunction

  task automatic send_cmd(input cmd_t c, input logic [ID_W-1:0] id, input logic typed,
                          input alloc_rslt_t typed_r);
    alloc_rslt_t r;
    if ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - CMD_W - ID_W){1'b0}}, id, c};
    do @(posedge clk); while (!in_tready);
    r = pool_step(c, id);
    owed_results.push_back(typed ? typed_r : r);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    in_tvalid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cap_q = v;
  endtask

  // mostly allocations plus add/release on live blocks, some noise
  task automatic pick_cmd(output cmd_t c, output logic [ID_W-1:0] id);
    int roll;
    int live_ids[$];
    roll = $urandom_range(99);
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      if (blk_cnt[i] != '0) live_ids.push_back(i + 1);
    end
    id = ID_W'($urandom_range(127));
    if (roll < 35) begin
      c = CMD_ALLOC;
    end else if (roll < 85) begin
      c = (roll < 55) ? CMD_ADD_REF : CMD_RELEASE;
      if (live_ids.size() != 0)
        id = ID_W'(live_ids[$urandom_range(live_ids.size() - 1)]);
    end else begin
      c = cmd_t'($urandom_range(3));
    end
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) stall_left <= stall_left - 1;
  end

  always @(posedge clk) begin
    out_tready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    alloc_rslt_t a;
    alloc_rslt_t e;
    if (rst_n && out_tvalid && out_tready) begin
      a.granted = out_tdata[OUT_GRANT_LSB +: ID_W];
      a.status  = status_t'(out_tdata[OUT_STATUS_LSB +: STATUS_W]);
      a.live    = out_tdata[OUT_LIVE_LSB +: ID_W];
      if (owed_results.size() == 0) begin
        if (bad_results < 10)
          $display("unexpected transaction: granted %0d status %0d live %0d",
                   a.granted, a.status, a.live);
        bad_results++;
      end else begin
        e = owed_results.pop_front();
        if (a.granted !== e.granted || a.status !== e.status || a.live !== e.live) begin
          if (bad_results < 10)
            $display("mismatch: granted %0d/%0d status %0d/%0d live %0d/%0d (exp/act)",
                     e.granted, a.granted, e.status, a.status, e.live, a.live);
          bad_results++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    cmd_t            c;
    logic [ID_W-1:0] id;
    for (int i = 0; i < NUM_BLOCKS; i++) blk_cnt[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].is_cfg)
        write_capacity(dir_tbl[i].arg);
      else
        send_cmd(dir_tbl[i].cmd, dir_tbl[i].arg, dir_tbl[i].typed, dir_tbl[i].res);
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       write_capacity(CAP_W'($urandom_range(2, 10)));
        1:       write_capacity(CAP_W'($urandom_range(0, 127)));
        default: write_capacity(CAP_RESET);
      endcase
      send_idle = (ph == 0) ? 21 : (ph == 1) ? 79 : 0;
      recv_idle <= (ph == 0) ? 79 : (ph == 1) ? 21 : 0;
      if (ph == 2) stall_left <= HOLD_OFF;
      repeat (RAND_ITEMS) begin
        pick_cmd(c, id);
        send_cmd(c, id, 1'b0, NO_RES);
      end
    end

    in_tvalid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (bad_results == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
